// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros for the GIF LZW decoder RTL.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled during reset
`define GLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication, checked in the next cycle
`define GLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/gld_pkg.sv -----
// Shared types, constants and helpers for the GIF LZW decoder.
// No dependencies.
package gld_pkg;

  localparam int CODE_W = 12;
  localparam int BUF_W  = 24;
  localparam int NFC_W  = 13;
  localparam int ADDR_W = 12;

  // Stop reasons
  localparam logic [2:0] STOP_RUN   = 3'd0;
  localparam logic [2:0] STOP_END   = 3'd1;
  localparam logic [2:0] STOP_FULL  = 3'd2;
  localparam logic [2:0] STOP_OVFL  = 3'd3;
  localparam logic [2:0] STOP_PIXEL = 3'd4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_CODE = 3'd0,
    CFG_PALETTE  = 3'd1,
    CFG_WIDTH    = 3'd2,
    CFG_HEIGHT   = 3'd3,
    CFG_INTERL   = 3'd4
  } cfg_idx_t;

  // Dictionary write bundle
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] prefix;
    logic [7:0]        suffix;
  } dict_wr_t;

  // Stack access bundle
  typedef struct packed {
    logic              wen;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              ren;
    logic [ADDR_W-1:0] raddr;
  } stk_acc_t;

  // Saturate a size register to 1..8
  function automatic logic [3:0] clamp18(input logic [3:0] v);
    if (v < 4'd1) return 4'd1;
    if (v > 4'd8) return 4'd8;
    return v;
  endfunction

endpackage

// ----- hw/rtl/gld_in_if.sv -----
// Input channel of the GIF LZW decoder: one tick of the raster stream.
// Depends on nothing.
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic       new_image;
  logic       byte_valid;
  logic [7:0] data_byte;

  modport source (output valid, new_image, byte_valid, data_byte, input ready);
  modport sink   (input valid, new_image, byte_valid, data_byte, output ready);
endinterface

// ----- hw/rtl/gld_out_if.sv -----
// Result channel of the GIF LZW decoder: one result per input tick.
// Depends on nothing.
interface gld_out_if;
  logic        valid;
  logic        ready;
  logic        byte_taken;
  logic        pixel_valid;
  logic [7:0]  pixel_index;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic        in_frame;
  logic        done_res;
  logic [2:0]  stop_reason;

  modport source (output valid, byte_taken, pixel_valid, pixel_index, pixel_x, pixel_y,
                  in_frame, done_res, stop_reason, input ready);
  modport sink   (input valid, byte_taken, pixel_valid, pixel_index, pixel_x, pixel_y,
                  in_frame, done_res, stop_reason, output ready);
endinterface

// ----- hw/rtl/gif_lzw_pixel_decoder_unit.sv -----
// GIF LZW pixel decoder: one input transaction in, one result out, one at a time.
// A transaction passes the check, decode, pop and finish states before its result is
// registered; the next is accepted only back in idle. A restart goes straight to finish.
// A data code whose chain visits dictionary entries adds a walk and a read state (one
// memory read) per entry; a result still waiting on the output holds the finish step.
// Reset (rst_n low, synchronous) loads register defaults and clears control state.
`include "assert_macros.svh"
module gif_lzw_pixel_decoder_unit
  import gld_pkg::*;
#(
  parameter int MAX_CODE_BITS = 12,
  parameter int TABLE_DEPTH   = 4096,
  parameter int STACK_DEPTH   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  gld_in_if.sink      in_ch,
  gld_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam logic [SCW-1:0]   STK_FULL = SCW'(STACK_DEPTH);
  localparam logic [NFC_W-1:0] TBL_LIM  = NFC_W'(TABLE_DEPTH);
  localparam logic [3:0]       CW_MAX   = 4'(MAX_CODE_BITS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_WALK = 7'b0001000,
    S_RDW  = 7'b0010000,
    S_POP  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [3:0]  mcs_r, pal_r;
  logic [15:0] w_r, h_r;
  logic        il_r;
  logic [31:0] limit_r;

  // Latched transaction
  logic        new_r, new_nxt, bv_r, bv_nxt;
  logic [7:0]  db_r, db_nxt;

  // Decoder state
  logic [SCW-1:0]    cnt_r, cnt_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [4:0]        bc_r, bc_nxt;
  logic [3:0]        cw_r, cw_nxt;
  logic [NFC_W-1:0]  nfc_r, nfc_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt, cur_r, cur_nxt, code_r, code_nxt;
  logic [7:0]        lfc_r, lfc_nxt;
  logic [15:0]       col_r, col_nxt, row_r, row_nxt;
  logic [1:0]        pass_r, pass_nxt;
  logic [31:0]       pdone_r, pdone_nxt;
  logic [2:0]        stop_r, stop_nxt;
  logic              first_r, first_nxt, oob_r, oob_nxt, pv_r, pv_nxt;

  // Output register
  logic        ov_r, ov_nxt, ob_r, ob_nxt, opv_r, opv_nxt, ofr_r, ofr_nxt;
  logic [7:0]  opi_r, opi_nxt;
  logic [15:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [2:0]  ost_r, ost_nxt;

  dict_wr_t          dwr;
  logic              drd_en;
  logic [ADDR_W-1:0] drd_addr;
  logic [CODE_W-1:0] d_prefix;
  logic [7:0]        d_suffix;
  stk_acc_t          sacc;
  logic [7:0]        s_rdata;

  logic              in_acc;
  logic [3:0]        mcs_c, pal_c;
  logic [NFC_W-1:0]  clear_c;
  logic [7:0]        mask_c;
  logic [CODE_W-1:0] code_c;

  gld_dict #(.TABLE_DEPTH(TABLE_DEPTH)) u_dict (
    .clk       (clk),
    .wr        (dwr),
    .rd_en     (drd_en),
    .rd_addr   (drd_addr),
    .rd_prefix (d_prefix),
    .rd_suffix (d_suffix)
  );

  gld_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .acc     (sacc),
    .rd_data (s_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign mcs_c   = clamp18(mcs_r);
  assign pal_c   = clamp18(pal_r);
  assign clear_c = NFC_W'(1) << mcs_c;
  assign mask_c  = 8'((9'd1 << pal_c) - 9'd1);
  assign code_c  = CODE_W'(buf_r & ((BUF_W'(1) << cw_r) - BUF_W'(1)));

  assign out_ch.valid       = ov_r;
  assign out_ch.byte_taken  = ob_r;
  assign out_ch.pixel_valid = opv_r;
  assign out_ch.pixel_index = opi_r;
  assign out_ch.pixel_x     = ox_r;
  assign out_ch.pixel_y     = oy_r;
  assign out_ch.in_frame    = ofr_r;
  assign out_ch.done_res    = (ost_r != STOP_RUN);
  assign out_ch.stop_reason = ost_r;

  // Configuration writes and pixel limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcs_r <= 4'd8;
      pal_r <= 4'd8;
      w_r   <= 16'd1;
      h_r   <= 16'd1;
      il_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_CODE: mcs_r <= cfg_wdata[3:0];
        CFG_PALETTE:  pal_r <= cfg_wdata[3:0];
        CFG_WIDTH:    w_r   <= cfg_wdata;
        CFG_HEIGHT:   h_r   <= cfg_wdata;
        CFG_INTERL:   il_r  <= cfg_wdata[0];
        default:      ;
      endcase
    end
    limit_r <= w_r * h_r;
  end

  // Sequencer
  always_comb begin
    logic [SCW-1:0]   c;
    logic [2:0]       st;
    logic [16:0]      r;
    logic [7:0]       root;
    logic [NFC_W-1:0] nf;
    state_nxt = state_r;
    new_nxt = new_r; bv_nxt = bv_r; db_nxt = db_r;
    cnt_nxt = cnt_r; buf_nxt = buf_r; bc_nxt = bc_r; cw_nxt = cw_r; nfc_nxt = nfc_r;
    prev_nxt = prev_r; cur_nxt = cur_r; code_nxt = code_r; lfc_nxt = lfc_r;
    col_nxt = col_r; row_nxt = row_r; pass_nxt = pass_r; pdone_nxt = pdone_r;
    stop_nxt = stop_r; first_nxt = first_r; oob_nxt = oob_r; pv_nxt = pv_r;
    ov_nxt = ov_r & ~out_ch.ready;
    ob_nxt = ob_r; opv_nxt = opv_r; opi_nxt = opi_r; ox_nxt = ox_r; oy_nxt = oy_r;
    ofr_nxt = ofr_r; ost_nxt = ost_r;
    dwr = '0;
    drd_en = 1'b0;
    drd_addr = cur_r;
    sacc = '0;
    sacc.waddr = ADDR_W'(cnt_r[SAW-1:0]);
    c = cnt_r; st = stop_r; r = '0; root = '0; nf = nfc_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_nxt = in_ch.new_image;
          bv_nxt  = in_ch.byte_valid;
          db_nxt  = in_ch.data_byte;
          pv_nxt  = 1'b0;
          if (in_ch.new_image) begin
            // Restart everything but the memories
            cnt_nxt = '0; buf_nxt = '0; bc_nxt = '0;
            cw_nxt = mcs_c + 4'd1; nfc_nxt = clear_c + NFC_W'(2);
            prev_nxt = '0; lfc_nxt = '0; col_nxt = '0; row_nxt = '0;
            pass_nxt = '0; pdone_nxt = '0; stop_nxt = STOP_RUN; first_nxt = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (stop_r == STOP_RUN && pdone_r >= limit_r) stop_nxt = STOP_PIXEL;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_POP;
        if (stop_r == STOP_RUN && cnt_r == '0 && {1'b0, bc_r} >= {2'b0, cw_r}) begin
          buf_nxt = buf_r >> cw_r;
          bc_nxt  = bc_r - {1'b0, cw_r};
          if ({1'b0, code_c} == clear_c + NFC_W'(1)) begin
            stop_nxt = STOP_END;
          end else if ({1'b0, code_c} == clear_c) begin
            cw_nxt = mcs_c + 4'd1;
            nfc_nxt = clear_c + NFC_W'(2);
            first_nxt = 1'b1;
          end else if (first_r) begin
            root = code_c[7:0] & mask_c;
            sacc.wen = 1'b1; sacc.wdata = root;
            cnt_nxt = cnt_r + SCW'(1);
            prev_nxt = code_c; lfc_nxt = root; first_nxt = 1'b0;
          end else if (nfc_r >= TBL_LIM) begin
            stop_nxt = STOP_FULL;
          end else begin
            code_nxt = code_c;
            cur_nxt = code_c;
            if ({1'b0, code_c} >= nfc_r) begin
              // Code not yet defined: previous string plus its first pixel
              sacc.wen = 1'b1; sacc.wdata = lfc_r;
              cnt_nxt = cnt_r + SCW'(1);
              cur_nxt = prev_r;
            end
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if ({1'b0, cur_r} >= clear_c) begin
          drd_en = 1'b1;
          oob_nxt = ({1'b0, cur_r} >= TBL_LIM);
          state_nxt = S_RDW;
        end else begin
          root = cur_r[7:0] & mask_c;
          state_nxt = S_POP;
          if (cnt_r >= STK_FULL) begin
            cnt_nxt = '0; stop_nxt = STOP_OVFL;
          end else begin
            sacc.wen = 1'b1; sacc.wdata = root;
            cnt_nxt = cnt_r + SCW'(1);
            dwr.en = 1'b1; dwr.addr = ADDR_W'(nfc_r); dwr.prefix = prev_r; dwr.suffix = root;
            prev_nxt = code_r; lfc_nxt = root;
            nf = nfc_r + NFC_W'(1);
            nfc_nxt = nf;
            if (nf >= (NFC_W'(1) << cw_r) && cw_r < CW_MAX) cw_nxt = cw_r + 4'd1;
          end
        end
      end
      S_RDW: begin
        // Push the entry's suffix and follow its prefix, or stop on stack overflow
        if (cnt_r >= STK_FULL) begin
          cnt_nxt = '0; stop_nxt = STOP_OVFL;
          state_nxt = S_POP;
        end else begin
          sacc.wen = 1'b1; sacc.wdata = oob_r ? 8'd0 : d_suffix;
          cnt_nxt = cnt_r + SCW'(1);
          cur_nxt = oob_r ? '0 : d_prefix;
          state_nxt = S_WALK;
        end
      end
      S_POP: begin
        if (stop_r == STOP_RUN && cnt_r != '0) begin
          c = cnt_r - SCW'(1);
          sacc.ren = 1'b1; sacc.raddr = ADDR_W'(c[SAW-1:0]);
          cnt_nxt = c; pv_nxt = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          opv_nxt = 1'b0; opi_nxt = '0; ox_nxt = '0; oy_nxt = '0; ofr_nxt = 1'b0;
          ob_nxt = 1'b0;
          if (pv_r) begin
            opv_nxt = 1'b1; opi_nxt = s_rdata; ox_nxt = col_r; oy_nxt = row_r;
            ofr_nxt = (row_r < h_r);
            // Advance the raster position
            r = {1'b0, row_r};
            if ({1'b0, col_r} + 17'd1 < {1'b0, w_r}) begin
              col_nxt = col_r + 16'd1;
            end else begin
              col_nxt = '0;
              if (!il_r) begin
                r = r + 17'd1;
              end else begin
                case (pass_r)
                  2'd0: begin
                    r = r + 17'd8;
                    if (r >= {1'b0, h_r}) begin pass_nxt = 2'd1; r = 17'd4; end
                  end
                  2'd1: begin
                    r = r + 17'd8;
                    if (r >= {1'b0, h_r}) begin pass_nxt = 2'd2; r = 17'd2; end
                  end
                  2'd2: begin
                    r = r + 17'd4;
                    if (r >= {1'b0, h_r}) begin pass_nxt = 2'd3; r = 17'd1; end
                  end
                  default: r = r + 17'd2;
                endcase
              end
              row_nxt = r[16] ? 16'hFFFF : r[15:0];
            end
            pdone_nxt = pdone_r + 32'd1;
            if (pdone_r + 32'd1 >= limit_r) st = STOP_PIXEL;
          end
          stop_nxt = st;
          // Take the offered byte into the bit buffer
          if (!new_r && st == STOP_RUN && bv_r && bc_r <= 5'd16) begin
            buf_nxt = buf_r | (BUF_W'(db_r) << bc_r);
            bc_nxt = bc_r + 5'd8;
            ob_nxt = 1'b1;
          end
          ost_nxt = st;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0; buf_r <= '0; bc_r <= '0;
      cw_r <= 4'd9; nfc_r <= NFC_W'(258);
      prev_r <= '0; lfc_r <= '0; col_r <= '0; row_r <= '0; pass_r <= '0;
      pdone_r <= '0; stop_r <= STOP_RUN; first_r <= 1'b1; pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt; buf_r <= buf_nxt; bc_r <= bc_nxt;
      cw_r <= cw_nxt; nfc_r <= nfc_nxt;
      prev_r <= prev_nxt; lfc_r <= lfc_nxt; col_r <= col_nxt; row_r <= row_nxt;
      pass_r <= pass_nxt; pdone_r <= pdone_nxt; stop_r <= stop_nxt;
      first_r <= first_nxt; pv_r <= pv_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    new_r <= new_nxt; bv_r <= bv_nxt; db_r <= db_nxt;
    cur_r <= cur_nxt; code_r <= code_nxt; oob_r <= oob_nxt;
    ob_r <= ob_nxt; opv_r <= opv_nxt; opi_r <= opi_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt;
    ofr_r <= ofr_nxt; ost_r <= ost_nxt;
  end

  `GLD_ASSERT(a_stack_bound, cnt_r <= STK_FULL, "string stack count above depth")
  `GLD_ASSERT_NEXT(a_result_from_fin, !ov_r, !ov_r || $past(state_r == S_FIN), "result without finish")
  `GLD_ASSERT_NEXT(a_stop_sticky, stop_r != STOP_RUN && !(in_acc && in_ch.new_image), stop_r == $past(stop_r), "stop reason changed without restart")
endmodule

// ----- hw/rtl/gld_dict.sv -----
// Prefix/suffix dictionary memory, one write and one registered read port.
// Depends on gld_pkg.
module gld_dict
  import gld_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic              clk,
  input  dict_wr_t          wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CODE_W-1:0] rd_prefix,
  output logic [7:0]        rd_suffix
);
  localparam int TAW = $clog2(TABLE_DEPTH);

  logic [CODE_W+7:0] mem [TABLE_DEPTH];
  logic [CODE_W+7:0] rdata_r;

  // Write a new entry; read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[TAW-1:0]] <= {wr.prefix, wr.suffix};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr[TAW-1:0]];
    end
  end

  assign rd_prefix = rdata_r[CODE_W+7:8];
  assign rd_suffix = rdata_r[7:0];
endmodule

// ----- hw/rtl/gld_stack.sv -----
// String stack memory: push port and registered pop-read port.
// Depends on gld_pkg.
module gld_stack
  import gld_pkg::*;
#(
  parameter int STACK_DEPTH = 4096
) (
  input  logic       clk,
  input  stk_acc_t   acc,
  output logic [7:0] rd_data
);
  localparam int SAW = $clog2(STACK_DEPTH);

  logic [7:0] mem [STACK_DEPTH];
  logic [7:0] rdata_r;

  // Push writes and pop reads
  always_ff @(posedge clk) begin
    if (acc.wen) begin
      mem[acc.waddr[SAW-1:0]] <= acc.wdata;
    end
    if (acc.ren) begin
      rdata_r <= mem[acc.raddr[SAW-1:0]];
    end
  end

  assign rd_data = rdata_r;
endmodule
